/* src/chwc_pkg.sv */
// ----------------------------------------------------------------------------
// chwc_pkg
// Shared constants, codes, command bundle and arctangent table for the
// compass heading unit with wheel interference compensation.
// ----------------------------------------------------------------------------
package chwc_pkg;

	// operation codes of an input beat
	localparam logic [1:0] OP_MEASURE = 2'd0;
	localparam logic [1:0] OP_CALIB   = 2'd1;
	localparam logic [1:0] OP_LOAD    = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_CENTER_X = 2'd0;
	localparam logic [1:0] REG_CENTER_Y = 2'd1;
	localparam logic [1:0] REG_Y_SCALE  = 2'd2;

	localparam int DEF_COEFS_PER_POLY = 4;
	localparam int NUM_POLYS          = 6;
	localparam int CORDIC_STEPS       = 16;

	// datapath widths: corrected sample, rotation vector, angle accumulator
	localparam int XW = 40;
	localparam int CW = 48;
	localparam int ZW = 20;

	localparam logic signed [16:0]   PI_Q12      = 17'sd12868;
	localparam logic signed [ZW-1:0] PI_Q16      = 20'sd205887;
	localparam logic signed [15:0]   Y_SCALE_RST = 16'sd4096;

	// command bundle from controller to datapath
	typedef struct packed {
		logic capture;
		logic rd;
		logic mac;
		logic apply;
		logic scale;
		logic pre;
		logic step;
		logic fin;
	} chwc_cmd_t;

	// arctangent of 2^-i in Q.16
	function automatic logic signed [ZW-1:0] atan_tab(input logic [3:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			4'd0:    r = 20'sd51472;
			4'd1:    r = 20'sd30385;
			4'd2:    r = 20'sd16055;
			4'd3:    r = 20'sd8150;
			4'd4:    r = 20'sd4091;
			4'd5:    r = 20'sd2047;
			4'd6:    r = 20'sd1024;
			4'd7:    r = 20'sd512;
			4'd8:    r = 20'sd256;
			4'd9:    r = 20'sd128;
			4'd10:   r = 20'sd64;
			4'd11:   r = 20'sd32;
			4'd12:   r = 20'sd16;
			4'd13:   r = 20'sd8;
			4'd14:   r = 20'sd4;
			default: r = 20'sd2;
		endcase
		return r;
	endfunction

endpackage

/* src/chwc_ctrl.sv */
// ----------------------------------------------------------------------------
// chwc_ctrl
// Sequencer: walks the six polynomials, the Y scale, the rotation steps and
// the result hand-off, and drives the datapath commands.
// ----------------------------------------------------------------------------
module chwc_ctrl #(
	parameter int COEFS_PER_POLY = chwc_pkg::DEF_COEFS_PER_POLY,
	parameter int AW = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_accept,
	input  logic [1:0]          in_opcode,
	input  logic                out_stall,
	output logic                in_stall,
	output logic                out_valid,
	output chwc_pkg::chwc_cmd_t cmd,
	output logic [AW-1:0]       addr,
	output logic [2:0]          poly,
	output logic [3:0]          step
);

	localparam int KW = (COEFS_PER_POLY > 1) ? $clog2(COEFS_PER_POLY) : 1;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_MAC, S_APPLY, S_SCALE, S_PRE, S_ROT, S_FIN
	} state_t;

	state_t        state_q;
	logic [KW-1:0] k_q;
	logic [AW-1:0] addr_q;
	logic [2:0]    poly_q;
	logic [3:0]    step_q;
	logic          out_valid_q;
	logic          fin_go;

	assign fin_go = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	// state, counters and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			addr_q      <= '0;
			poly_q      <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					k_q    <= '0;
					addr_q <= '0;
					poly_q <= '0;
					step_q <= '0;
					if (in_accept) begin
						if (in_opcode == chwc_pkg::OP_MEASURE ||
								in_opcode == chwc_pkg::OP_CALIB)
							state_q <= S_RD;
						else
							state_q <= S_FIN;
					end
				end
				S_RD: state_q <= S_MAC;
				S_MAC: begin
					if (k_q == KW'(COEFS_PER_POLY - 1)) begin
						state_q <= S_APPLY;
					end else begin
						k_q     <= k_q + 1'b1;
						addr_q  <= addr_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_APPLY: begin
					k_q    <= '0;
					addr_q <= addr_q + 1'b1;
					if (poly_q == 3'(chwc_pkg::NUM_POLYS - 1)) begin
						state_q <= S_SCALE;
					end else begin
						poly_q  <= poly_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_SCALE: state_q <= S_PRE;
				S_PRE:   state_q <= S_ROT;
				S_ROT: begin
					step_q <= step_q + 1'b1;
					if (step_q == 4'(chwc_pkg::CORDIC_STEPS - 1))
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd         = '0;
		cmd.capture = in_accept;
		cmd.rd      = (state_q == S_RD);
		cmd.mac     = (state_q == S_MAC);
		cmd.apply   = (state_q == S_APPLY);
		cmd.scale   = (state_q == S_SCALE);
		cmd.pre     = (state_q == S_PRE);
		cmd.step    = (state_q == S_ROT);
		cmd.fin     = fin_go;
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign addr      = addr_q;
	assign poly      = poly_q;
	assign step      = step_q;

endmodule

/* src/chwc_dp.sv */
// ----------------------------------------------------------------------------
// chwc_dp
// Datapath: configuration registers, coefficient memory, Horner
// multiply-add, Y scaling, CORDIC vectoring and the result register.
// ----------------------------------------------------------------------------
module chwc_dp #(
	parameter int COEFS_PER_POLY = chwc_pkg::DEF_COEFS_PER_POLY,
	parameter int AW = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [15:0]               cfg_data,
	input  chwc_pkg::chwc_cmd_t       cmd,
	input  logic [AW-1:0]             addr,
	input  logic [2:0]                poly,
	input  logic [3:0]                step,
	input  logic [1:0]                opcode,
	input  logic signed [15:0]        mag_x,
	input  logic signed [15:0]        mag_y,
	input  logic signed [15:0]        left_wheel_angle,
	input  logic signed [15:0]        right_wheel_angle,
	input  logic signed [15:0]        back_wheel_angle,
	input  logic signed [15:0]        desired_angle,
	input  logic [4:0]                coef_index,
	input  logic signed [31:0]        coef_value,
	output logic signed [16:0]        heading,
	output logic signed [16:0]        offset_now
);

	localparam int NCOEF = chwc_pkg::NUM_POLYS * COEFS_PER_POLY;
	localparam int XW    = chwc_pkg::XW;
	localparam int CW    = chwc_pkg::CW;
	localparam int ZW    = chwc_pkg::ZW;
	localparam int MW    = XW + 16;

	logic signed [15:0]   center_x_q, center_y_q, y_scale_q;
	logic [31:0]          mem_q [NCOEF];
	logic [NCOEF-1:0]     vld_q;
	logic [31:0]          rd_q;
	logic                 rv_q;
	logic [1:0]           op_q;
	logic signed [15:0]   ang_q [3];
	logic signed [15:0]   desired_q;
	logic signed [31:0]   acc_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0] z_q;
	logic                 zr_q;
	logic signed [16:0]   offset_q;
	logic signed [16:0]   heading_q, offnow_q;

	// input wrap and centering
	function automatic logic signed [15:0] wrap(input logic signed [15:0] a);
		logic signed [16:0] e;
		e = 17'(a);
		return (e > chwc_pkg::PI_Q12) ? 16'(e - chwc_pkg::PI_Q12) : a;
	endfunction

	function automatic logic signed [16:0] sat17(input logic signed [18:0] v);
		logic signed [16:0] r;
		if (v > 19'sd65535)
			r = 17'sd65535;
		else if (v < -19'sd65536)
			r = -17'sd65536;
		else
			r = 17'(v);
		return r;
	endfunction

	logic signed [16:0] dx0, dy0;
	assign dx0 = 17'(mag_x) - 17'(center_x_q);
	assign dy0 = 17'(mag_y) - 17'(center_y_q);

	// horner multiply-add
	logic signed [31:0] coef;
	logic [1:0]         wheel;
	logic signed [15:0] a_sel;
	logic signed [47:0] prod, rnd;
	logic signed [36:0] hsum;
	logic signed [31:0] hsat;

	assign coef  = rv_q ? $signed(rd_q) : 32'sd0;
	assign wheel = (poly < 3'd3) ? poly[1:0] : 2'(poly - 3'd3);
	assign a_sel = ang_q[wheel];
	assign prod  = acc_q * a_sel;
	assign rnd   = prod + 48'sd2048;
	assign hsum  = 37'($signed(rnd[47:12])) + 37'(coef);
	always_comb begin
		if (hsum > 37'sd2147483647)
			hsat = 32'sh7fffffff;
		else if (hsum < -37'sd2147483648)
			hsat = 32'sh80000000;
		else
			hsat = 32'(hsum);
	end

	// y scale
	logic signed [MW-1:0] ymul, yrnd;
	assign ymul = y_q * y_scale_q;
	assign yrnd = ymul + MW'(2048);

	// cordic rotation
	logic signed [CW-1:0] sx, sy;
	assign sx = cy_q >>> step;
	assign sy = cx_q >>> step;

	// final heading
	logic signed [ZW-1:0] zr8;
	logic signed [15:0]   raw;
	logic signed [16:0]   new_off;
	assign zr8     = z_q + ZW'(8);
	assign raw     = zr_q ? 16'sd0 : 16'($signed(zr8[ZW-1:4]));
	assign new_off = sat17(19'(desired_q) - 19'(raw));

	// configuration registers and offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			y_scale_q  <= chwc_pkg::Y_SCALE_RST;
			offset_q   <= '0;
			vld_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					chwc_pkg::REG_CENTER_X: center_x_q <= $signed(cfg_data);
					chwc_pkg::REG_CENTER_Y: center_y_q <= $signed(cfg_data);
					chwc_pkg::REG_Y_SCALE:  y_scale_q  <= $signed(cfg_data);
					default: ;
				endcase
			end
			if (cmd.capture && opcode == chwc_pkg::OP_LOAD &&
					({1'b0, coef_index} < 6'(NCOEF)))
				vld_q[AW'(coef_index)] <= 1'b1;
			if (cmd.fin && op_q == chwc_pkg::OP_CALIB)
				offset_q <= new_off;
		end
	end

	// coefficient memory
	always_ff @(posedge clk) begin
		if (cmd.capture && opcode == chwc_pkg::OP_LOAD &&
				({1'b0, coef_index} < 6'(NCOEF)))
			mem_q[AW'(coef_index)] <= coef_value;
		if (cmd.rd) begin
			rd_q <= mem_q[addr];
			rv_q <= vld_q[addr];
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= opcode;
			ang_q[0]  <= wrap(left_wheel_angle);
			ang_q[1]  <= wrap(right_wheel_angle);
			ang_q[2]  <= wrap(back_wheel_angle);
			desired_q <= desired_angle;
			acc_q     <= '0;
			x_q       <= {{(XW-37){dx0[16]}}, dx0, 20'd0};
			y_q       <= {{(XW-37){dy0[16]}}, dy0, 20'd0};
		end
		if (cmd.mac)
			acc_q <= hsat;
		if (cmd.apply) begin
			acc_q <= '0;
			if (poly < 3'd3)
				x_q <= x_q - XW'(acc_q);
			else
				y_q <= y_q - XW'(acc_q);
		end
		if (cmd.scale) begin
			cx_q <= CW'(x_q);
			cy_q <= CW'($signed(yrnd[MW-1:12]));
		end
		if (cmd.pre) begin
			zr_q <= (cx_q == '0) && (cy_q == '0);
			if (cx_q < 0) begin
				cx_q <= -cx_q;
				cy_q <= -cy_q;
				z_q  <= (cy_q >= 0) ? chwc_pkg::PI_Q16 : -chwc_pkg::PI_Q16;
			end else begin
				z_q <= '0;
			end
		end
		if (cmd.step) begin
			if (cy_q >= 0) begin
				cx_q <= cx_q + sx;
				cy_q <= cy_q - sy;
				z_q  <= z_q + chwc_pkg::atan_tab(step);
			end else begin
				cx_q <= cx_q - sx;
				cy_q <= cy_q + sy;
				z_q  <= z_q - chwc_pkg::atan_tab(step);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= '0;
			offnow_q  <= '0;
		end else if (cmd.fin) begin
			case (op_q)
				chwc_pkg::OP_MEASURE: begin
					heading_q <= sat17(19'(raw) + 19'(offset_q));
					offnow_q  <= offset_q;
				end
				chwc_pkg::OP_CALIB: begin
					heading_q <= sat17(19'(raw) + 19'(new_off));
					offnow_q  <= new_off;
				end
				default: begin
					heading_q <= '0;
					offnow_q  <= offset_q;
				end
			endcase
		end
	end

	assign heading    = heading_q;
	assign offset_now = offnow_q;

endmodule

/* src/compass_heading_with_wheel_compensation_unit.sv */
// ----------------------------------------------------------------------------
// compass_heading_with_wheel_compensation_unit
// Magnetometer heading with steering interference removal and offset trim.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_stall) carry a measure, calibrate or coefficient
// load operation; each gives exactly one result beat (out_valid/out_stall)
// with heading and offset_now. The unit works on one beat at a time and
// holds in_stall high while busy.
// A measure or calibrate beat goes from accept to result through these steps:
// a coefficient memory read and a pass through the single Horner multiply-add
// for each of the COEFS_PER_POLY coefficients (four by default), a subtract
// for each polynomial, the Y scale multiply, a fold of the vector into the
// right half plane, sixteen CORDIC steps and the result step. The next beat
// is taken once the unit is back in idle after the result forms. A load or
// unused beat goes from accept straight to the result step.
// The result sits in an output register, so a new beat is taken while a
// result waits; a beat that finishes while the receiver stalls waits in the
// last step until the output register frees.
// Reset clears the centers, sets y_scale to one, zeroes the heading offset
// and marks every stored coefficient as zero.
// Configuration writes are taken at any cycle the write enable is high.
// ----------------------------------------------------------------------------
module compass_heading_with_wheel_compensation_unit #(
	parameter int COEFS_PER_POLY = chwc_pkg::DEF_COEFS_PER_POLY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic signed [15:0] mag_x,
	input  logic signed [15:0] mag_y,
	input  logic signed [15:0] left_wheel_angle,
	input  logic signed [15:0] right_wheel_angle,
	input  logic signed [15:0] back_wheel_angle,
	input  logic signed [15:0] desired_angle,
	input  logic [4:0]         coef_index,
	input  logic signed [31:0] coef_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [16:0] heading,
	output logic signed [16:0] offset_now
);

	localparam int NCOEF = chwc_pkg::NUM_POLYS * COEFS_PER_POLY;
	localparam int AW    = $clog2(NCOEF);

	chwc_pkg::chwc_cmd_t cmd;
	logic [AW-1:0]       addr;
	logic [2:0]          poly;
	logic [3:0]          step;
	logic                in_accept;

	assign in_accept = in_valid && !in_stall;

	chwc_ctrl #(
		.COEFS_PER_POLY(COEFS_PER_POLY),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_accept(in_accept),
		.in_opcode(opcode),
		.out_stall(out_stall),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.cmd(cmd),
		.addr(addr),
		.poly(poly),
		.step(step)
	);

	chwc_dp #(
		.COEFS_PER_POLY(COEFS_PER_POLY),
		.AW(AW)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.addr(addr),
		.poly(poly),
		.step(step),
		.opcode(opcode),
		.mag_x(mag_x),
		.mag_y(mag_y),
		.left_wheel_angle(left_wheel_angle),
		.right_wheel_angle(right_wheel_angle),
		.back_wheel_angle(back_wheel_angle),
		.desired_angle(desired_angle),
		.coef_index(coef_index),
		.coef_value(coef_value),
		.heading(heading),
		.offset_now(offset_now)
	);

	// an accepted beat makes the unit busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall)
		else $error("unit not busy after accepting a beat");

	// a result only appears after a busy period
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work");

	// result payload only changes when a new result is presented
	a_offset_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(offset_now) |-> out_valid)
		else $error("offset_now changed with no result");

endmodule
